[hw/rtl/conv2d_rgb_valid_window_clamp_core_macros.svh]
// Assertion macros for the port checker of the convolution core.
// Depends on nothing; included by the checker only.
`ifndef CONV2D_RGB_VALID_WINDOW_CLAMP_CORE_MACROS_SVH
`define CONV2D_RGB_VALID_WINDOW_CLAMP_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CV_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Check that a signal holds while a stalled request waits.
`define CV_HOLD(label, clk, rst_n, stall, sig) \
  label: assert property (@(posedge clk) disable iff (!rst_n) stall |=> $stable(sig)) \
    else $error("stalled signal changed");
`endif

[hw/rtl/cv2d_pkg.sv]
// Package of the RGB 2-D convolution core: sizes, widths, types and helpers.
// Depends on nothing; used by the front, queue, back and top RTL files.
package cv2d_pkg;
  localparam int unsigned Ksize    = 5;
  localparam int unsigned NTaps    = Ksize * Ksize;
  localparam int unsigned MaxWidth = 2048;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned ColW     = $clog2(MaxWidth);
  localparam int unsigned RowW     = $clog2(MaxHeight);
  localparam int unsigned WidthW   = 12;
  localparam int unsigned HeightW  = 13;
  localparam int unsigned CfgW     = 13;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned TapW     = $clog2(NTaps);
  localparam int unsigned PixW     = 24;
  localparam int unsigned ProdW    = 25;
  localparam int unsigned AccW     = 32;
  localparam logic [15:0] SatQ88   = 16'd65280;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);

  localparam logic [CfgIdxW-1:0] RegWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] RegHeight = 1'b1;

  typedef enum logic {KindCoef = 1'b0, KindPixel = 1'b1} kind_e;

  // One window ready for the multiply-accumulate back part.
  typedef struct packed {
    logic [NTaps-1:0][PixW-1:0] win;
    logic                       last;
  } win_t;

  // Clamp a Q.12 sum to unsigned Q8.8.
  function automatic logic [15:0] clamp_q88(input logic signed [AccW-1:0] acc);
    logic [AccW-1:0] sh;
    begin
      sh = $unsigned(acc) >> 4;
      if (acc < 0) clamp_q88 = 16'd0;
      else if (sh > AccW'(SatQ88)) clamp_q88 = SatQ88;
      else clamp_q88 = sh[15:0];
    end
  endfunction
endpackage

[hw/rtl/cv2d_if.sv]
// Valid/ready stream interfaces for the input requests and the results.
// Depends on nothing.
interface cv2d_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [4:0]  coef_index;
  logic signed [15:0] coef_value;
  logic        first_of_frame;
  logic [7:0]  chan0;
  logic [7:0]  chan1;
  logic [7:0]  chan2;
  modport source (output valid, kind, coef_index, coef_value, first_of_frame,
                  chan0, chan1, chan2, input ready);
  modport sink (input valid, kind, coef_index, coef_value, first_of_frame,
                chan0, chan1, chan2, output ready);
endinterface

interface cv2d_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out0;
  logic [15:0] out1;
  logic [15:0] out2;
  logic        last_of_frame;
  modport source (output valid, out0, out1, out2, last_of_frame, input ready);
  modport sink (input valid, out0, out1, out2, last_of_frame, output ready);
endinterface

[hw/rtl/cv2d_front.sv]
// Front part: counts raster position, keeps line buffers and the window,
// and pushes one window per valid position. Depends on cv2d_pkg.
module cv2d_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        is_pix_i,
  input  logic                        first_i,
  input  logic [cv2d_pkg::PixW-1:0]   pix_i,
  input  logic [cv2d_pkg::WidthW-1:0] width_i,
  input  logic [cv2d_pkg::HeightW-1:0] height_i,
  output logic                        push_o,
  output cv2d_pkg::win_t              win_o
);
  import cv2d_pkg::*;

  logic [Ksize-2:0][PixW-1:0] line_mem [MaxWidth];
  logic [NTaps-1:0][PixW-1:0] win_q, win_d;
  logic [ColW-1:0] col_q, col_d, col;
  logic [RowW-1:0] row_q, row_d, row;
  logic [12:0] w, h;
  logic [Ksize-2:0][PixW-1:0] rd_q;
  logic [Ksize-1:0][PixW-1:0] newcol;
  logic take;
  logic valid_win;
  logic last_pix;
  logic s_v_q;
  logic [ColW-1:0] s_col_q;
  logic [PixW-1:0] s_pix_q;
  logic s_win_ok_q;
  logic s_last_q;

  // Effective width and height after range folding.
  always_comb begin
    w = (width_i == '0) ? 13'd1 : (width_i > WidthW'(MaxWidth)) ? 13'(MaxWidth)
        : 13'(width_i);
    h = (height_i == '0) ? 13'd1 : (height_i > HeightW'(MaxHeight)) ? 13'(MaxHeight)
        : height_i;
  end

  assign take = en_i && is_pix_i;

  // Current position, restarted by the frame mark or by a shrunk size.
  always_comb begin
    col = first_i ? '0 : col_q;
    row = first_i ? '0 : row_q;
    if ({2'b0, col} >= w) col = '0;
    if ({1'b0, row} >= h) row = '0;
    if ({2'b0, col} + 13'd1 >= w) begin
      col_d = '0;
      row_d = ({1'b0, row} + 13'd1 >= h) ? '0 : row + 1'b1;
    end else begin
      col_d = col + 1'b1;
      row_d = row;
    end
  end

  assign valid_win = ({2'b0, col} + 13'd1 >= 13'(Ksize))
                     && ({1'b0, row} + 13'd1 >= 13'(Ksize));
  assign last_pix = ({1'b0, row} + 13'd1 == h) && ({2'b0, col} + 13'd1 == w);

  // Position counters and the valid bit of the second stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      s_v_q <= 1'b0;
    end else begin
      s_v_q <= take;
      if (take) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  // Pixel, column and flags carried into the second stage.
  always_ff @(posedge clk_i) begin
    if (take) begin
      s_col_q <= col;
      s_pix_q <= pix_i;
      s_win_ok_q <= valid_win;
      s_last_q <= last_pix;
    end
  end

  // New window column and shifted window.
  always_comb begin
    for (int r = 0; r < Ksize - 1; r++) newcol[r] = rd_q[r];
    newcol[Ksize-1] = s_pix_q;
    for (int r = 0; r < Ksize; r++) begin
      for (int c = 0; c < Ksize - 1; c++) win_d[r*Ksize+c] = win_q[r*Ksize+c+1];
      win_d[r*Ksize+Ksize-1] = newcol[r];
    end
  end

  // Line memory: the second stage writes back, the first stage reads the next
  // column into a register, taking the write data when both hit one column.
  always_ff @(posedge clk_i) begin
    if (s_v_q) line_mem[s_col_q] <= newcol[Ksize-1:1];
    if (take) begin
      if (s_v_q && s_col_q == col) rd_q <= newcol[Ksize-1:1];
      else rd_q <= line_mem[col];
    end
  end

  // Window registers advance with the second stage.
  always_ff @(posedge clk_i) begin
    if (s_v_q) win_q <= win_d;
  end

  assign push_o = s_v_q && s_win_ok_q;
  assign win_o.win = win_d;
  assign win_o.last = s_last_q;
endmodule

[hw/rtl/cv2d_queue.sv]
// Short FIFO of windows between the front and the back part.
// Depends on cv2d_pkg.
module cv2d_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cv2d_pkg::win_t data_i,
  output logic           space_o,
  output logic           avail_o,
  input  logic           pop_i,
  output cv2d_pkg::win_t data_o
);
  import cv2d_pkg::*;

  win_t mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0] cnt_q;

  assign space_o = cnt_q < (QPtrW+1)'(QDepth - 1);
  assign avail_o = cnt_q != '0;
  assign data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QPtrW+1)'(push_i) - (QPtrW+1)'(pop_i);
    end
  end
endmodule

[hw/rtl/cv2d_back.sv]
// Back part: multiplies the window by the kernel, reduces the products in a
// registered tree, clamps and drives the result register. Depends on cv2d_pkg.
module cv2d_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             avail_i,
  output logic                             pop_o,
  input  cv2d_pkg::win_t                   win_i,
  input  logic [cv2d_pkg::NTaps-1:0][15:0] coef_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic [15:0]                      out0_o,
  output logic [15:0]                      out1_o,
  output logic [15:0]                      out2_o,
  output logic                             last_o
);
  import cv2d_pkg::*;

  // Stage 1 products, stage 2 sums of five, stage 3 totals, stage 4 output.
  logic [2:0][NTaps-1:0][ProdW-1:0] prod_d, prod_q;
  logic [2:0][Ksize-1:0][AccW-1:0]  part_d, part_q;
  logic [2:0][AccW-1:0]             tot_q;
  logic [3:0] v_q;
  logic [2:0] l_q;
  logic [2:0][15:0] res_q;
  logic adv;

  // The whole pipe moves when the output register is free or being taken.
  assign adv = !v_q[3] || ready_i;
  assign pop_o = adv && avail_i;

  // Signed products of each channel byte with its coefficient.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int t = 0; t < NTaps; t++)
        prod_d[ch][t] = $signed({{(ProdW-8){1'b0}}, win_i.win[t][8*ch +: 8]})
                        * $signed({{(ProdW-16){coef_i[t][15]}}, coef_i[t]});
    end
  end

  // Row sums of the registered products, sign extended.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < Ksize; r++) begin
        part_d[ch][r] = '0;
        for (int c = 0; c < Ksize; c++)
          part_d[ch][r] = part_d[ch][r] + AccW'($signed(prod_q[ch][r*Ksize+c]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q <= prod_d;
      part_q <= part_d;
      for (int ch = 0; ch < 3; ch++) begin
        tot_q[ch] <= part_q[ch][0] + part_q[ch][1] + part_q[ch][2]
                   + part_q[ch][3] + part_q[ch][4];
        res_q[ch] <= clamp_q88(tot_q[ch]);
      end
      l_q <= {l_q[1:0], win_i.last};
      last_o <= l_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (adv) v_q <= {v_q[2:0], pop_o};
  end

  assign valid_o = v_q[3];
  assign out0_o = res_q[0];
  assign out1_o = res_q[1];
  assign out2_o = res_q[2];
endmodule

[hw/rtl/conv2d_rgb_valid_window_clamp_core.sv]
// RGB 5x5 convolution core: line buffers, window, kernel MAC and clamp.
// Accepts one pixel request per cycle; a result is registered in the front, the
// queue and the back part. The front stalls only when the window queue fills
// under output back-pressure. A coefficient request waits until no window is
// queued or about to be queued. Asynchronous active-low reset clears counters,
// queue and valid bits; line, window and coefficient storage are not cleared.
module conv2d_rgb_valid_window_clamp_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cv2d_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [cv2d_pkg::CfgW-1:0]    cfg_data_i,
  cv2d_in_if.sink                      in_if,
  cv2d_out_if.source                   out_if
);
  import cv2d_pkg::*;

  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic [NTaps-1:0][15:0] coef_q;
  logic en, push, space, avail, pop;
  win_t win_f, win_b;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthW'(644);
      height_q <= HeightW'(484);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegWidth: width_q <= cfg_data_i[WidthW-1:0];
        RegHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Coefficient requests must not overtake windows still waiting for the kernel.
  assign in_if.ready = (in_if.kind == KindCoef) ? (space && !avail && !push) : space;
  assign en = in_if.valid && in_if.ready;

  // Kernel coefficient store.
  always_ff @(posedge clk_i) begin
    if (en && in_if.kind == KindCoef && in_if.coef_index < 5'(NTaps))
      coef_q[in_if.coef_index[TapW-1:0]] <= in_if.coef_value;
  end

  cv2d_front u_front (
    .clk_i, .rst_ni, .en_i(en), .is_pix_i(in_if.kind == KindPixel),
    .first_i(in_if.first_of_frame),
    .pix_i({in_if.chan2, in_if.chan1, in_if.chan0}),
    .width_i(width_q), .height_i(height_q), .push_o(push), .win_o(win_f)
  );

  cv2d_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(win_f), .space_o(space),
    .avail_o(avail), .pop_i(pop), .data_o(win_b)
  );

  cv2d_back u_back (
    .clk_i, .rst_ni, .avail_i(avail), .pop_o(pop), .win_i(win_b), .coef_i(coef_q),
    .valid_o(out_if.valid), .ready_i(out_if.ready), .out0_o(out_if.out0),
    .out1_o(out_if.out1), .out2_o(out_if.out2), .last_o(out_if.last_of_frame)
  );
endmodule

[hw/rtl/cv2d_checker.sv]
// Port-level checker of the convolution core, bound to the top level.
// Depends on the macros header.
`include "conv2d_rgb_valid_window_clamp_core_macros.svh"
module cv2d_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out0,
  input logic [15:0] out1,
  input logic [15:0] out2
);
  `CV_HOLD(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out0)
  `CV_ASSERT(a_sat0, clk_i, rst_ni, out_valid |-> out0 <= 16'd65280)
  `CV_ASSERT(a_sat1, clk_i, rst_ni, out_valid |-> out1 <= 16'd65280)
  `CV_ASSERT(a_sat2, clk_i, rst_ni, out_valid |-> out2 <= 16'd65280)
endmodule

bind conv2d_rgb_valid_window_clamp_core cv2d_checker u_checker (
  .clk_i, .rst_ni, .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out0(out_if.out0), .out1(out_if.out1), .out2(out_if.out2)
);

[tb/conv2d_checker.sv]
// Checker for the RGB convolution core: watches the config port and both streams,
// predicts each filtered pixel and compares it with what the core delivers.
// Depends on cv2d_pkg and the stream interfaces in cv2d_if.sv.
module conv2d_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [cv2d_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [cv2d_pkg::CfgW-1:0]    cfg_data_i,
  cv2d_in_if                           in_mon,
  cv2d_out_if                          out_mon,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o,
  output int unsigned                  results_o
);
  import cv2d_pkg::*;

  typedef struct packed {
    logic [15:0] out0;
    logic [15:0] out1;
    logic [15:0] out2;
    logic        last;
  } filt_pix_t;

  filt_pix_t          filt_expect_q[$];
  logic signed [15:0] kernel   [NTaps];
  logic [PixW-1:0]    line_mem [Ksize-1][MaxWidth];
  logic [PixW-1:0]    window   [NTaps];
  int unsigned        col_cnt;
  int unsigned        row_cnt;
  logic [WidthW-1:0]  width_reg;
  logic [HeightW-1:0] height_reg;

  assign pending_o = filt_expect_q.size();

  // Negative sums give zero, others drop four fraction bits and saturate at 255.0.
  function automatic logic [15:0] to_q88(input longint acc);
    longint sh;
    if (acc < 0) return 16'd0;
    sh = acc >>> 4;
    if (sh > longint'(SatQ88)) return SatQ88;
    return sh[15:0];
  endfunction

  // Advance the window by one pixel and queue a result when it is fully inside.
  task automatic filter_pixel(input logic fof, input logic [PixW-1:0] pix);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    int unsigned row;
    logic [PixW-1:0] newcol [Ksize];
    longint acc [3];
    filt_pix_t res;
    w = (width_reg == 0) ? 1 : width_reg;
    if (w > MaxWidth) w = MaxWidth;
    h = (height_reg == 0) ? 1 : height_reg;
    if (h > MaxHeight) h = MaxHeight;
    if (fof) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    if (col_cnt >= w) col_cnt = 0;
    if (row_cnt >= h) row_cnt = 0;
    col = col_cnt;
    row = row_cnt;
    for (int r = 0; r < Ksize - 1; r++) newcol[r] = line_mem[r][col];
    newcol[Ksize-1] = pix;
    for (int r = 0; r < Ksize; r++) begin
      for (int c = 0; c < Ksize - 1; c++) window[r*Ksize+c] = window[r*Ksize+c+1];
      window[r*Ksize+Ksize-1] = newcol[r];
    end
    for (int r = 0; r < Ksize - 1; r++) line_mem[r][col] = newcol[r+1];
    if (col + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col_cnt = col + 1;
    end
    if (col + 1 < Ksize || row + 1 < Ksize) return;
    acc = '{0, 0, 0};
    for (int t = 0; t < NTaps; t++) begin
      for (int ch = 0; ch < 3; ch++) begin
        acc[ch] += longint'(window[t][8*ch +: 8]) * longint'(kernel[t]);
      end
    end
    res.out0 = to_q88(acc[0]);
    res.out1 = to_q88(acc[1]);
    res.out2 = to_q88(acc[2]);
    res.last = (row + 1 == h) && (col + 1 == w);
    filt_expect_q.push_back(res);
  endtask

  // Track configuration and requests, then match delivered results in order.
  always @(posedge clk_i or negedge rst_ni) begin
    filt_pix_t exp_pix;
    if (!rst_ni) begin
      col_cnt = 0;
      row_cnt = 0;
      width_reg = 644;
      height_reg = 484;
      fail_count_o = 0;
      results_o = 0;
      foreach (kernel[i]) kernel[i] = '0;
      foreach (window[i]) window[i] = '0;
      foreach (line_mem[r, c]) line_mem[r][c] = '0;
      filt_expect_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegWidth) width_reg = cfg_data_i[WidthW-1:0];
        else if (cfg_idx_i == RegHeight) height_reg = cfg_data_i[HeightW-1:0];
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.kind == KindCoef) begin
          if (in_mon.coef_index < NTaps) kernel[in_mon.coef_index] = in_mon.coef_value;
        end else begin
          filter_pixel(in_mon.first_of_frame,
                       {in_mon.chan2, in_mon.chan1, in_mon.chan0});
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        results_o++;
        if (filt_expect_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("Unexpected result %h %h %h last %b", out_mon.out0, out_mon.out1,
                     out_mon.out2, out_mon.last_of_frame);
        end else begin
          exp_pix = filt_expect_q.pop_front();
          if (out_mon.out0 !== exp_pix.out0 || out_mon.out1 !== exp_pix.out1 ||
              out_mon.out2 !== exp_pix.out2 || out_mon.last_of_frame !== exp_pix.last) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("Mismatch: expected %h %h %h last %b, got %h %h %h last %b",
                       exp_pix.out0, exp_pix.out1, exp_pix.out2, exp_pix.last,
                       out_mon.out0, out_mon.out1, out_mon.out2, out_mon.last_of_frame);
          end
        end
      end
    end
  end
endmodule

[tb/tb_top.sv]
// Top of the convolution core testbench: clock, reset, stimulus and verdict.
// Depends on cv2d_pkg, cv2d_if.sv, the core and tb/conv2d_checker.sv.
module tb_top;
  import cv2d_pkg::*;

  localparam int unsigned IdleLimit = 20000;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_data;
  int unsigned        fail_count;
  int unsigned        pending;
  int unsigned        results;
  int unsigned        send_idle_pct;
  int unsigned        stall_pct;
  int unsigned        requests_sent;
  int unsigned        quiet_cycles;

  cv2d_in_if  in_bus ();
  cv2d_out_if out_bus ();

  conv2d_rgb_valid_window_clamp_core u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_if     (in_bus),
    .out_if    (out_bus)
  );

  conv2d_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_mon      (in_bus),
    .out_mon     (out_bus),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (results)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Random back-pressure on the result side.
  always @(posedge clk_i) begin
    out_bus.ready <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Send one request, with random idle cycles before it.
  task automatic send_req(input kind_e kind, input logic [4:0] idx,
                          input logic [15:0] val, input logic fof,
                          input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid          <= 1'b1;
    in_bus.kind           <= kind;
    in_bus.coef_index     <= idx;
    in_bus.coef_value     <= val;
    in_bus.first_of_frame <= fof;
    in_bus.chan0          <= c0;
    in_bus.chan1          <= c1;
    in_bus.chan2          <= c2;
    // Ready is looked at mid-cycle, where it holds the value of the coming edge.
    do @(negedge clk_i); while (!in_bus.ready);
    @(posedge clk_i);
    requests_sent++;
  endtask

  task automatic send_pixel(input logic fof);
    send_req(KindPixel, 5'($urandom), 16'($urandom), fof,
             8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Load a full kernel; extreme sets saturate, the others mostly stay in range.
  task automatic load_kernel(input bit extreme);
    logic [15:0] v;
    for (int t = 0; t < NTaps; t++) begin
      if (extreme) v = $urandom_range(1) ? 16'h8000 : 16'h7fff;
      else v = 16'($signed($urandom_range(400)) - 80);
      send_req(KindCoef, 5'(t), v, 1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // Wait for the core to drain, then write both size registers.
  task automatic set_size(input logic [CfgW-1:0] w, input logic [CfgW-1:0] h);
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (10) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= RegWidth;
    cfg_data <= w;
    @(posedge clk_i);
    cfg_idx  <= RegHeight;
    cfg_data <= h;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // One random frame with occasional coefficient updates and stray frame marks.
  task automatic send_frame(input int unsigned npix, input bit marked);
    for (int unsigned p = 0; p < npix; p++) begin
      if ($urandom_range(29) == 0)
        send_req(KindCoef, 5'($urandom), 16'($signed($urandom_range(400)) - 80), 1'b0,
                 8'($urandom), 8'($urandom), 8'($urandom));
      send_pixel((p == 0 && marked) || ($urandom_range(149) == 0));
    end
  endtask

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned budget;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = RegWidth;
    cfg_data = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    requests_sent = 0;
    in_bus.valid = 1'b0;
    in_bus.kind = KindCoef;
    in_bus.coef_index = '0;
    in_bus.coef_value = '0;
    in_bus.first_of_frame = 1'b0;
    in_bus.chan0 = '0;
    in_bus.chan1 = '0;
    in_bus.chan2 = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: smallest frame, extreme kernel and pixels, ignored loads.
    set_size(13'd5, 13'd5);
    load_kernel(1'b1);
    send_req(KindCoef, 5'd31, 16'hffff, 1'b0, 8'd0, 8'd0, 8'd0);
    send_req(KindCoef, 5'd25, 16'h0000, 1'b0, 8'd0, 8'd0, 8'd0);
    for (int p = 0; p < 25; p++) begin
      logic [7:0] ext;
      ext = p[0] ? 8'hff : 8'h00;
      send_req(KindPixel, 5'd0, 16'd0, p == 0, ext, ~ext, ext);
    end
    load_kernel(1'b0);
    send_frame(50, 1'b1);

    // Widths and heights below the window, zero acting as one.
    set_size(13'd0, 13'd0);
    send_frame(8, 1'b1);
    set_size(13'd3, 13'd7);
    send_frame(21, 1'b1);
    set_size(13'd9, 13'd1);
    send_frame(20, 1'b1);

    // Out-of-range register values folded to the largest width and height.
    set_size(13'h0fff, 13'd5);
    send_frame(150, 1'b1);
    set_size(13'd5, 13'h1fff);
    send_frame(60, 1'b1);

    // Random frames over the four idling phases.
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 78; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 78; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      budget = requests_sent + 130;
      while (requests_sent < budget) begin
        w = ($urandom_range(5) == 0) ? $urandom_range(16, 10) : $urandom_range(9, 5);
        h = $urandom_range(8, 5);
        set_size(CfgW'(w), CfgW'(h));
        load_kernel($urandom_range(7) == 0);
        send_frame(w * h, 1'b1);
        // Sometimes run straight into the next frame without a mark.
        if ($urandom_range(3) == 0) send_frame(w * h, 1'b0);
      end
    end

    in_bus.valid <= 1'b0;
    stall_pct = 0;
    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    $display("Sent %0d requests over all sizes and idling phases; checked %0d results.",
             requests_sent, results);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
